### src/hdlc_bit_stuffing_framer_unit_assert.svh
// assertion macros for the hdlc bit stuffing framer
// no dependencies; included by the modules that carry assertions
`ifndef HDLC_BIT_STUFFING_FRAMER_UNIT_ASSERT_SVH
`define HDLC_BIT_STUFFING_FRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define HBSF_ASSERT_HOLDS(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbsf assertion failed");

// next-cycle implication
`define HBSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbsf assertion failed");

`endif

### src/hbsf_pkg.sv
// shared types and constants of the hdlc bit stuffing framer
// no dependencies
package hbsf_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PRE_W   = 6;
  localparam int unsigned PAD_W   = 3;
  localparam int unsigned RUN_W   = 3;
  localparam int unsigned ACC_W   = 9;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned STUFF_W = 10;
  localparam int unsigned SCNT_W  = 4;
  localparam int unsigned COMB_W  = 17;

  localparam logic [BYTE_W-1:0] FLAG_BYTE    = 8'h7E;
  localparam logic [RUN_W-1:0]  STUFF_RUN    = 3'd5;
  localparam logic [PRE_W-1:0]  MAX_PREAMBLE = 6'd62;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_END   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_done;
    logic [PAD_W-1:0]  pad_bits;
  } result_t;

  typedef struct packed {
    logic [STUFF_W-1:0] bits;
    logic [SCNT_W-1:0]  count;
    logic [RUN_W-1:0]   run;
  } stuff_t;

endpackage

### src/hbsf_channels.sv
// channel interfaces of the hdlc bit stuffing framer
// depends on hbsf_pkg
interface hbsf_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [hbsf_pkg::CMD_W-1:0]  cmd;
  logic [hbsf_pkg::BYTE_W-1:0] data_byte;
  modport source (output valid, cmd, data_byte, input ready);
  modport sink (input valid, cmd, data_byte, output ready);
endinterface

interface hbsf_res_if;
  logic                       valid;
  logic                       ready;
  logic [hbsf_pkg::BYTE_W-1:0] out_byte;
  logic                       run_last;
  logic                       frame_done;
  logic [hbsf_pkg::PAD_W-1:0]  pad_bits;
  modport source (output valid, out_byte, run_last, frame_done, pad_bits, input ready);
  modport sink (input valid, out_byte, run_last, frame_done, pad_bits, output ready);
endinterface

interface hbsf_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [hbsf_pkg::PRE_W-1:0] preamble_flags;
  modport source (output valid, preamble_flags, input ready);
  modport sink (input valid, preamble_flags, output ready);
endinterface

### src/hbsf_in_stage.sv
// input register of the framer: holds one command until the core takes it
// depends on hbsf_pkg and hbsf_channels
module hbsf_in_stage (
  input  logic              clk,
  input  logic              rst,
  hbsf_cmd_if.sink          cmd_ch,
  input  logic              take,
  output logic              item_valid,
  output hbsf_pkg::item_t   item
);
  import hbsf_pkg::*;

  assign cmd_ch.ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd_ch.valid && cmd_ch.ready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ch.valid && cmd_ch.ready) begin
      item.cmd       <= cmd_ch.cmd;
      item.data_byte <= cmd_ch.data_byte;
    end
  end

endmodule

### src/hbsf_stuffer.sv
// bit stuffer: expands one data byte, lsb first, inserting a zero after five ones
// depends on hbsf_pkg
module hbsf_stuffer (
  input  logic [hbsf_pkg::BYTE_W-1:0] data_byte,
  input  logic [hbsf_pkg::RUN_W-1:0]  run_in,
  output hbsf_pkg::stuff_t           stuff
);
  import hbsf_pkg::*;

  always_comb begin
    logic [STUFF_W-1:0] bits;
    logic [SCNT_W-1:0]  n;
    logic [RUN_W-1:0]   r;
    bits = '0;
    n    = '0;
    r    = run_in;
    for (int i = 0; i < BYTE_W; i++) begin
      bits[n] = data_byte[i];
      n = n + 1'b1;
      if (data_byte[i]) begin
        r = r + 1'b1;
        if (r >= STUFF_RUN) begin
          bits[n] = 1'b0;
          n = n + 1'b1;
          r = '0;
        end
      end else begin
        r = '0;
      end
    end
    stuff.bits  = bits;
    stuff.count = n;
    stuff.run   = r;
  end

endmodule

### src/hbsf_core.sv
// framing core: bit accumulator, flag sequencer and result register
// depends on hbsf_pkg, hbsf_channels and the assertion macro header
`include "hdlc_bit_stuffing_framer_unit_assert.svh"

module hbsf_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  hbsf_pkg::item_t            item,
  output logic                       take,
  input  logic [hbsf_pkg::PRE_W-1:0] preamble_flags,
  input  hbsf_pkg::stuff_t           stuff,
  output logic [hbsf_pkg::RUN_W-1:0] ones_run,
  hbsf_res_if.source                 res_ch
);
  import hbsf_pkg::*;

  logic [ACC_W-1:0] acc, acc_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [RUN_W-1:0] ones_run_next;
  logic [PRE_W-1:0] flag_left, flag_left_next;
  logic             pad_pend, pad_pend_next;
  logic             ovalid;
  result_t          ores, e_res;
  logic             emit, slot_free, busy;

  logic [COMB_W-1:0] comb, stream;
  logic [CNT_W:0]    total, total_rem;
  logic [CNT_W-1:0]  drain_rem;
  logic [PRE_W-1:0]  lim;

  assign slot_free = !ovalid || res_ch.ready;
  assign busy      = (cnt >= CNT_W'(BYTE_W)) || pad_pend || (flag_left != '0);
  assign take      = item_valid && slot_free && !busy;

  assign comb      = {{(COMB_W-ACC_W){1'b0}}, acc}
                   | ({{(COMB_W-STUFF_W){1'b0}}, stuff.bits} << cnt);
  assign stream    = {{(COMB_W-ACC_W){1'b0}}, acc}
                   | ({{(COMB_W-BYTE_W){1'b0}}, FLAG_BYTE} << cnt);
  assign total     = {1'b0, cnt} + {1'b0, stuff.count};
  assign total_rem = total - (CNT_W+1)'(BYTE_W);
  assign drain_rem = cnt - CNT_W'(BYTE_W);
  assign lim       = (preamble_flags > MAX_PREAMBLE) ? MAX_PREAMBLE : preamble_flags;

  always_comb begin
    acc_next       = acc;
    cnt_next       = cnt;
    ones_run_next  = ones_run;
    flag_left_next = flag_left;
    pad_pend_next  = pad_pend;
    emit           = 1'b0;
    e_res          = '0;
    if (slot_free) begin
      if (flag_left != '0) begin
        emit           = 1'b1;
        e_res.out_byte = FLAG_BYTE;
        e_res.run_last = (flag_left == PRE_W'(1));
        flag_left_next = flag_left - 1'b1;
      end else if (pad_pend) begin
        emit             = 1'b1;
        e_res.out_byte   = acc[BYTE_W-1:0];
        e_res.run_last   = 1'b1;
        e_res.frame_done = 1'b1;
        e_res.pad_bits   = PAD_W'(0) - cnt[PAD_W-1:0];
        acc_next         = '0;
        cnt_next         = '0;
        pad_pend_next    = 1'b0;
      end else if (cnt >= CNT_W'(BYTE_W)) begin
        emit           = 1'b1;
        e_res.out_byte = acc[BYTE_W-1:0];
        e_res.run_last = (drain_rem < CNT_W'(BYTE_W));
        acc_next       = {{BYTE_W{1'b0}}, acc[ACC_W-1:BYTE_W]};
        cnt_next       = drain_rem;
      end else if (item_valid) begin
        unique case (item.cmd)
          CMD_START: begin
            emit           = 1'b1;
            e_res.out_byte = FLAG_BYTE;
            e_res.run_last = (lim == '0);
            flag_left_next = lim;
            acc_next       = '0;
            cnt_next       = '0;
            ones_run_next  = '0;
          end
          CMD_DATA: begin
            ones_run_next = stuff.run;
            if (total >= (CNT_W+1)'(BYTE_W)) begin
              emit           = 1'b1;
              e_res.out_byte = comb[BYTE_W-1:0];
              e_res.run_last = (total_rem < (CNT_W+1)'(BYTE_W));
              acc_next       = comb[BYTE_W+ACC_W-1:BYTE_W];
              cnt_next       = total_rem[CNT_W-1:0];
            end else begin
              acc_next = comb[ACC_W-1:0];
              cnt_next = total[CNT_W-1:0];
            end
          end
          CMD_END: begin
            emit           = 1'b1;
            e_res.out_byte = stream[BYTE_W-1:0];
            ones_run_next  = '0;
            if (cnt == '0) begin
              e_res.run_last   = 1'b1;
              e_res.frame_done = 1'b1;
              acc_next         = '0;
            end else begin
              acc_next      = stream[BYTE_W+ACC_W-1:BYTE_W];
              pad_pend_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      ones_run  <= '0;
      flag_left <= '0;
      pad_pend  <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      acc       <= acc_next;
      cnt       <= cnt_next;
      ones_run  <= ones_run_next;
      flag_left <= flag_left_next;
      pad_pend  <= pad_pend_next;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (res_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ores <= e_res;
    end
  end

  assign res_ch.valid      = ovalid;
  assign res_ch.out_byte   = ores.out_byte;
  assign res_ch.run_last   = ores.run_last;
  assign res_ch.frame_done = ores.frame_done;
  assign res_ch.pad_bits   = ores.pad_bits;

  `HBSF_ASSERT_HOLDS(a_done_is_last, clk, rst, ovalid && ores.frame_done, ores.run_last)
  `HBSF_ASSERT_HOLDS(a_pad_with_done, clk, rst, ovalid && (ores.pad_bits != '0), ores.frame_done)
  `HBSF_ASSERT_HOLDS(a_pad_pend_cnt, clk, rst, pad_pend, (cnt != '0) && (cnt < CNT_W'(BYTE_W)))
  `HBSF_ASSERT_NEXT(a_pad_clears, clk, rst, pad_pend && slot_free && (flag_left == '0), (cnt == '0) && !pad_pend)

endmodule

### src/hdlc_bit_stuffing_framer_unit.sv
// HDLC transmit framer: one output byte leaves the result register per clock at most, so
// the rate is set by that register and the receiver. A start command emits a flag, then
// min(preamble_flags, 62) more; a data command emits up to two bytes, an end command the
// closing flag and a padded byte if bits remain, an unused command nothing. While a
// result waits at the output, one further command can be held in the input register.
// depends on hbsf_pkg, hbsf_channels, hbsf_in_stage, hbsf_stuffer, hbsf_core
module hdlc_bit_stuffing_framer_unit (
  input  logic       clk,
  input  logic       rst,
  hbsf_cmd_if.sink   cmd_ch,
  hbsf_res_if.source res_ch,
  hbsf_cfg_if.sink   cfg
);
  import hbsf_pkg::*;

  logic [PRE_W-1:0] preamble_flags;
  logic             item_valid;
  logic             take;
  item_t            item;
  stuff_t           stuff;
  logic [RUN_W-1:0] ones_run;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_flags <= '0;
    end else if (cfg.valid) begin
      preamble_flags <= cfg.preamble_flags;
    end
  end

  hbsf_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .cmd_ch     (cmd_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  hbsf_stuffer u_stuffer (
    .data_byte (item.data_byte),
    .run_in    (ones_run),
    .stuff     (stuff)
  );

  hbsf_core u_core (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item           (item),
    .take           (take),
    .preamble_flags (preamble_flags),
    .stuff          (stuff),
    .ones_run       (ones_run),
    .res_ch         (res_ch)
  );

endmodule

### tb/hbsf_frame_checker.sv
// watches the command, config and result channels of the framer and predicts the framed bytes
// depends on hbsf_pkg and hbsf_channels
module hbsf_frame_checker (
  input  logic clk,
  input  logic rst,
  hbsf_cmd_if  cmd_mon,
  hbsf_res_if  res_mon,
  hbsf_cfg_if  cfg_mon,
  output int   fail_count,
  output int   bytes_checked,
  output int   outstanding
);
  import hbsf_pkg::*;

  result_t          framed_q[$];
  result_t          item_bytes[$];
  logic [6:0]       part_bits;
  logic [2:0]       part_cnt;
  logic [2:0]       ones_seen;
  logic [PRE_W-1:0] flags_cfg;

  assign outstanding = framed_q.size();

  function automatic void shift_bit(input logic b);
    result_t r;
    if (part_cnt == 3'd7) begin
      r = '0;
      r.out_byte = {b, part_bits};
      item_bytes.push_back(r);
      part_bits = '0;
      part_cnt = '0;
    end else begin
      part_bits[part_cnt] = b;
      part_cnt = part_cnt + 3'd1;
    end
  endfunction

  function automatic void shift_flag();
    int i;
    for (i = 0; i < BYTE_W; i++) shift_bit(FLAG_BYTE[i]);
  endfunction

  function automatic void clear_bits();
    part_bits = '0;
    part_cnt = '0;
    ones_seen = '0;
  endfunction

  function automatic void frame_command(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d);
    int               i;
    logic [PRE_W-1:0] nflags;
    logic [PAD_W-1:0] fill;
    result_t          r;
    item_bytes.delete();
    case (c)
      CMD_START: begin
        clear_bits();
        nflags = (flags_cfg > MAX_PREAMBLE) ? MAX_PREAMBLE : flags_cfg;
        for (i = 0; i <= int'(nflags); i++) shift_flag();
      end
      CMD_DATA: begin
        for (i = 0; i < BYTE_W; i++) begin
          shift_bit(d[i]);
          if (d[i]) begin
            ones_seen = ones_seen + 3'd1;
            if (ones_seen >= STUFF_RUN) begin
              shift_bit(1'b0);
              ones_seen = '0;
            end
          end else begin
            ones_seen = '0;
          end
        end
      end
      CMD_END: begin
        fill = 3'd0 - part_cnt;
        shift_flag();
        if (fill != '0) begin
          r = '0;
          r.out_byte = {1'b0, part_bits};
          item_bytes.push_back(r);
        end
        clear_bits();
        r = item_bytes.pop_back();
        r.frame_done = 1'b1;
        r.pad_bits = fill;
        item_bytes.push_back(r);
      end
      default: ;
    endcase
    if (item_bytes.size() > 0) begin
      r = item_bytes.pop_back();
      r.run_last = 1'b1;
      item_bytes.push_back(r);
    end
    foreach (item_bytes[k]) framed_q.push_back(item_bytes[k]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0h got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      framed_q.delete();
      clear_bits();
      flags_cfg = '0;
      fail_count = 0;
      bytes_checked = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) flags_cfg = cfg_mon.preamble_flags;
      if (cmd_mon.valid && cmd_mon.ready) frame_command(cmd_mon.cmd, cmd_mon.data_byte);
      if (res_mon.valid && res_mon.ready) begin
        if (framed_q.size() == 0) begin
          $error("out_byte expected none got %0h", res_mon.out_byte);
          fail_count++;
        end else begin
          want = framed_q.pop_front();
          bytes_checked++;
          check_field("out_byte", want.out_byte, res_mon.out_byte);
          check_field("run_last", 8'(want.run_last), 8'(res_mon.run_last));
          check_field("frame_done", 8'(want.frame_done), 8'(res_mon.frame_done));
          check_field("pad_bits", 8'(want.pad_bits), 8'(res_mon.pad_bits));
        end
      end
    end
  end

endmodule

### tb/tb_hdlc_bit_stuffing_framer_unit.sv
// top of the framer testbench: clock, reset, command and config stimulus, receiver stalls
// depends on hbsf_pkg, hbsf_channels, hbsf_frame_checker and the framer rtl
module tb_hdlc_bit_stuffing_framer_unit;
  import hbsf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;
  localparam int               SETTLE_CYCLES = 24;
  localparam int               HOLD_CYCLES   = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_fired = 1'b0;
  logic cfg_fired = 1'b0;
  int   fail_count;
  int   bytes_checked;
  int   outstanding;
  int   src_idle_pct = 0;
  int   sink_stall_pct = 0;
  int   hold_ask = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   frames_sent = 0;

  hbsf_cmd_if cmd_ch ();
  hbsf_res_if res_ch ();
  hbsf_cfg_if cfg_ch ();

  always #4 clk = ~clk;

  hdlc_bit_stuffing_framer_unit uut (
    .clk    (clk),
    .rst    (rst),
    .cmd_ch (cmd_ch),
    .res_ch (res_ch),
    .cfg    (cfg_ch)
  );

  hbsf_frame_checker frame_chk (
    .clk           (clk),
    .rst           (rst),
    .cmd_mon       (cmd_ch),
    .res_mon       (res_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .bytes_checked (bytes_checked),
    .outstanding   (outstanding)
  );

  always @(posedge clk) begin
    cmd_fired <= cmd_ch.valid && cmd_ch.ready;
    cfg_fired <= cfg_ch.valid && cfg_ch.ready;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_ch.ready = 1'b0;
        hold_left--;
      end else begin
        res_ch.ready = ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    #3200000;
    $display("FAIL");
    $finish;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] d);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid = 1'b0;
      cmd_ch.cmd = CMD_W'($urandom);
      cmd_ch.data_byte = BYTE_W'($urandom);
      @(negedge clk);
    end
    cmd_ch.valid = 1'b1;
    cmd_ch.cmd = c;
    cmd_ch.data_byte = d;
    do @(negedge clk); while (!cmd_fired);
    items_sent++;
  endtask

  task automatic write_flags(input logic [PRE_W-1:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.preamble_flags = v;
    do @(negedge clk); while (!cfg_fired);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    cmd_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] payload_byte();
    case ($urandom_range(3))
      0: return 8'hFF;
      1: return BYTE_W'($urandom | $urandom);
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input int nbytes, input bit closed);
    int i;
    send_cmd(CMD_START, BYTE_W'($urandom));
    for (i = 0; i < nbytes; i++) send_cmd(CMD_DATA, payload_byte());
    if (closed) send_cmd(CMD_END, BYTE_W'($urandom));
    frames_sent++;
  endtask

  task automatic random_traffic(input int n);
    int target;
    int nbytes;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) begin
        nbytes = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(4);
        send_frame(nbytes, $urandom_range(9) != 0);
      end else begin
        send_cmd(CMD_W'($urandom_range(3)), BYTE_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input logic [PRE_W-1:0] flags, input int idle, input int stall,
                           input int n);
    write_flags(flags);
    src_idle_pct = idle;
    sink_stall_pct <= stall;
    random_traffic(n);
    settle();
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_START;
    cmd_ch.data_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.preamble_flags = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: no start, stuffing across bytes, unused command, restart inside a frame
    write_flags(6'd0);
    send_cmd(CMD_DATA, 8'hFF);
    send_cmd(CMD_END, 8'h00);
    send_cmd(CMD_END, 8'hFF);
    send_cmd(CMD_START, 8'h00);
    send_cmd(CMD_DATA, 8'h00);
    send_cmd(CMD_DATA, 8'hFF);
    send_cmd(CMD_DATA, 8'h1F);
    send_cmd(CMD_DATA, 8'hF8);
    send_cmd(CMD_DATA, 8'h3E);
    send_cmd(CMD_DATA, 8'h7E);
    send_cmd(CMD_DATA, 8'h01);
    send_cmd(CMD_UNUSED, 8'hFF);
    send_cmd(CMD_END, 8'h00);
    send_cmd(CMD_START, 8'hFF);
    send_cmd(CMD_DATA, 8'hAA);
    send_cmd(CMD_START, 8'h00);
    send_cmd(CMD_DATA, 8'h80);
    send_cmd(CMD_END, 8'h00);
    settle();
    write_flags(6'd63);
    send_cmd(CMD_START, 8'h00);
    send_cmd(CMD_DATA, 8'h55);
    send_cmd(CMD_END, 8'h00);
    settle();

    run_phase(6'd0, 0, 0, 60);
    run_phase(6'd3, 55, 0, 60);
    run_phase(6'd1, 0, 55, 60);
    run_phase(PRE_W'($urandom_range(7)), 21, 21, 60);

    // receiver held off while the sender keeps offering a long frame
    write_flags(6'd62);
    src_idle_pct = 0;
    sink_stall_pct <= 0;
    hold_ask <= hold_ask + 1;
    send_frame(16, 1'b1);
    settle();

    $display("%0d commands in %0d frames over preamble counts 0 to 63, idle and stall mixes",
             items_sent, frames_sent);
    $display("%0d framed bytes compared", bytes_checked);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
